>>> design/bds_pkg.sv
`timescale 1ns / 1ps
// bds_pkg: shared constants, controller/datapath command and status structs,
// and small lookup functions for the box downsampler. No dependencies.
package bds_pkg;

   localparam int BlockEdge      = 8;
   localparam int SampleBitsDflt = 16;
   localparam int FactorW        = 3;

   localparam logic [0:0] CSR_HORIZ = 1'b0;
   localparam logic [0:0] CSR_VERT  = 1'b1;

   typedef struct packed {
      logic       acc;        // accumulate the accepted sample
      logic       div_load;   // load divider with |sum[col]|
      logic       div_step;   // one restoring divide step
      logic       div_write;  // store quotient of column col
      logic       pad_rd;     // read mirror row, column col
      logic       pad_wr;     // copy read word into current row, column col
      logic       out_load;   // move staged row to the output register
      logic       pad_row;    // out_load belongs to a padding row
      logic [2:0] col;
   } bds_cmd_type;

   typedef struct packed {
      logic row_done;    // accepted sample completes an output row
      logic final_line;  // latched final-line flag of the current row
      logic out_free;    // output register can take a row this cycle
      logic block_end;   // current row is row 7
   } bds_status_type;

   function automatic logic [2:0] clamp_factor(input logic [FactorW-1:0] f);
      logic [2:0] r;
      if (f == 3'd0) r = 3'd1;
      else if (f > 3'd4) r = 3'd4;
      else r = f;
      return r;
   endfunction

   // Column index pos / h, limited to 7; h is already clamped to 1..4.
   function automatic logic [2:0] column_of(input logic [4:0] pos, input logic [2:0] h);
      logic [4:0] q;
      logic [9:0] m;
      m = 10'(pos) * 10'd11;
      case (h)
         3'd1: q = pos;
         3'd2: q = {1'b0, pos[4:1]};
         3'd3: q = m[9:5];
         default: q = {2'b0, pos[4:2]};
      endcase
      return (q > 5'd7) ? 3'd7 : q[2:0];
   endfunction

endpackage

>>> design/bds_ctrl.sv
`timescale 1ns / 1ps
// bds_ctrl: sequencer of the box downsampler (accept, per-column divide,
// padding copy, output hand-off). Depends on bds_pkg.
module bds_ctrl
   import bds_pkg::*;
#(
   parameter int SUM_W = SampleBitsDflt + 4
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  bds_status_type st,
   output bds_cmd_type    cmd
);

   localparam int StepW = $clog2(SUM_W + 2);
   localparam logic [StepW-1:0] LastStep = StepW'(SUM_W + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_LOAD, S_PAD_RD, S_PAD_WR, S_PAD_LOAD
   } state_type;

   state_type        state_ff, state_in;
   logic [2:0]       col_ff, col_in;
   logic [StepW-1:0] step_ff, step_in;

   always_comb begin
      state_in   = state_ff;
      col_in     = col_ff;
      step_in    = step_ff;
      cmd        = '0;
      cmd.col    = col_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.acc    = req_tvalid;
            if (req_tvalid && st.row_done) begin
               state_in = S_DIV;
               col_in   = 3'd0;
               step_in  = '0;
            end
         end
         S_DIV: begin
            if (step_ff == '0) begin
               cmd.div_load = 1'b1;
               step_in      = step_ff + 1'b1;
            end else if (step_ff == LastStep) begin
               cmd.div_write = 1'b1;
               step_in       = '0;
               col_in        = col_ff + 3'd1;
               if (col_ff == 3'd7) state_in = S_LOAD;
            end else begin
               cmd.div_step = 1'b1;
               step_in      = step_ff + 1'b1;
            end
         end
         S_LOAD: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               col_in       = 3'd0;
               state_in     = (st.final_line && !st.block_end) ? S_PAD_RD : S_IDLE;
            end
         end
         S_PAD_RD: begin
            cmd.pad_rd = 1'b1;
            state_in   = S_PAD_WR;
         end
         S_PAD_WR: begin
            cmd.pad_wr = 1'b1;
            col_in     = col_ff + 3'd1;
            state_in   = (col_ff == 3'd7) ? S_PAD_LOAD : S_PAD_RD;
         end
         S_PAD_LOAD: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               cmd.pad_row  = 1'b1;
               col_in       = 3'd0;
               state_in     = st.block_end ? S_IDLE : S_PAD_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         col_ff   <= 3'd0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         step_ff  <= step_in;
      end
   end

   a_acc_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.acc |-> state_ff == S_IDLE)
      else $error("sample taken outside idle");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> st.out_free)
      else $error("output overwritten");
   a_row_div: assert property (@(posedge clock) disable iff (reset)
      (cmd.acc && st.row_done) |=> cmd.div_load && cmd.col == 3'd0)
      else $error("row end did not start divide");
   a_pad_seq: assert property (@(posedge clock) disable iff (reset)
      cmd.pad_rd |=> cmd.pad_wr && $stable(col_ff))
      else $error("pad read not followed by write");

endmodule

>>> design/bds_datapath.sv
`timescale 1ns / 1ps
// bds_datapath: accumulators, serial divider, row store, staging and
// output registers, and the factor registers. Depends on bds_pkg.
module bds_datapath
   import bds_pkg::*;
#(
   parameter int SAMPLE_BITS = SampleBitsDflt,
   parameter int SUM_W       = SAMPLE_BITS + 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [0:0]             csr_addr,
   input  logic [FactorW-1:0]     csr_wdata,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic                   line_is_final,
   input  logic                   rsp_tready,
   output logic                   rsp_valid,
   output logic [SAMPLE_BITS-1:0] rsp_col [BlockEdge],
   output logic [2:0]             rsp_row,
   output logic                   rsp_last,
   input  bds_cmd_type            cmd,
   output bds_status_type         st
);

   logic [FactorW-1:0]     horiz_ff, vert_ff;
   logic signed [SUM_W-1:0] sum_ff [BlockEdge];
   logic [4:0]             pos_ff;
   logic [2:0]             lines_ff, row_ff, mirror_ff;
   logic                   final_ff;
   logic [4:0]             norm_ff;
   logic [SUM_W-1:0]       quo_ff;
   logic [4:0]             rem_ff;
   logic                   neg_ff;
   logic [SAMPLE_BITS-1:0] stage_ff [BlockEdge];
   logic [SAMPLE_BITS-1:0] mem [BlockEdge*BlockEdge];
   logic [SAMPLE_BITS-1:0] rd_ff;
   logic                   valid_ff;
   logic [SAMPLE_BITS-1:0] out_ff [BlockEdge];
   logic [2:0]             out_row_ff;
   logic                   out_last_ff;

   logic [2:0]       hc, vc, acc_col, lines_inc;
   logic             line_end, row_done;
   logic [5:0]       t;
   logic             q_bit;
   logic [SUM_W-1:0] quo_signed;
   logic [SAMPLE_BITS-1:0] wr_data;
   logic [5:0]       norm_full;

   always_comb begin
      hc        = clamp_factor(horiz_ff);
      vc        = clamp_factor(vert_ff);
      acc_col   = column_of(pos_ff, hc);
      line_end  = (6'(pos_ff) + 6'd1) >= {hc, 3'b000};
      lines_inc = lines_ff + 3'd1;
      row_done  = line_end && ((lines_inc >= vc) || line_is_final);
      norm_full = 6'(lines_inc) * 6'(hc);
      t         = {rem_ff, quo_ff[SUM_W-1]};
      q_bit     = (t >= 6'(norm_ff));
      quo_signed = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
      wr_data   = cmd.pad_wr ? rd_ff : quo_signed[SAMPLE_BITS-1:0];
   end

   assign st.row_done   = row_done;
   assign st.final_line = final_ff;
   assign st.out_free   = !valid_ff || rsp_tready;
   assign st.block_end  = (row_ff == 3'd7);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         horiz_ff  <= 3'd1;
         vert_ff   <= 3'd1;
         pos_ff    <= 5'd0;
         lines_ff  <= 3'd0;
         row_ff    <= 3'd0;
         mirror_ff <= 3'd0;
         final_ff  <= 1'b0;
         valid_ff  <= 1'b0;
         for (int c = 0; c < BlockEdge; c++) sum_ff[c] <= '0;
      end else begin
         if (csr_we) begin
            if (csr_addr == CSR_HORIZ) horiz_ff <= csr_wdata;
            else vert_ff <= csr_wdata;
         end
         if (cmd.acc) begin
            sum_ff[acc_col] <= sum_ff[acc_col] + SUM_W'($signed(sample));
            if (line_end) begin
               pos_ff   <= 5'd0;
               lines_ff <= lines_inc;
            end else begin
               pos_ff <= pos_ff + 5'd1;
            end
            if (row_done) final_ff <= line_is_final;
         end
         if (cmd.div_write) sum_ff[cmd.col] <= '0;
         if (cmd.out_load) begin
            // block end clears the mirror pointer
            if (row_ff == 3'd7) mirror_ff <= 3'd0;
            else if (cmd.pad_row)
               mirror_ff <= (mirror_ff != 3'd0) ? mirror_ff - 3'd1 : 3'd0;
            else mirror_ff <= row_ff;
            if (!cmd.pad_row) lines_ff <= 3'd0;
            row_ff <= row_ff + 3'd1;
         end
         if (cmd.out_load) valid_ff <= 1'b1;
         else if (rsp_tready) valid_ff <= 1'b0;
      end
   end

   // divider and payload
   always_ff @(posedge clock) begin
      if (cmd.acc && row_done) norm_ff <= norm_full[4:0];
      if (cmd.div_load) begin
         neg_ff <= sum_ff[cmd.col][SUM_W-1];
         quo_ff <= sum_ff[cmd.col][SUM_W-1] ? (~sum_ff[cmd.col] + 1'b1) : sum_ff[cmd.col];
         rem_ff <= 5'd0;
      end else if (cmd.div_step) begin
         rem_ff <= q_bit ? 5'(t - 6'(norm_ff)) : t[4:0];
         quo_ff <= {quo_ff[SUM_W-2:0], q_bit};
      end
      if (cmd.div_write || cmd.pad_wr) stage_ff[cmd.col] <= wr_data;
      if (cmd.out_load) begin
         out_ff      <= stage_ff;
         out_row_ff  <= row_ff;
         out_last_ff <= (row_ff == 3'd7);
      end
   end

   // finished-row store
   always_ff @(posedge clock) begin
      if (cmd.div_write || cmd.pad_wr) mem[{row_ff, cmd.col}] <= wr_data;
      if (cmd.pad_rd) rd_ff <= mem[{mirror_ff, cmd.col}];
   end

   assign rsp_valid = valid_ff;
   assign rsp_col   = out_ff;
   assign rsp_row   = out_row_ff;
   assign rsp_last  = out_last_ff;

endmodule

>>> design/box_downsampler_8x8_block.sv
`timescale 1ns / 1ps
// box_downsampler_8x8_block: top level of the box-filter downsampler.
// Depends on bds_pkg, bds_ctrl and bds_datapath.
//
// Usage:
//  req_*  : one source sample per word, lines of 8*h samples, left to right.
//           tuser carries the final-line flag (only the line's last word counts).
//  rsp_*  : one averaged 8-sample row per word; tlast marks row 7 of the block.
//  csr_*  : write-only factor registers (0 = horizontal, 1 = vertical),
//           written only while the block is idle; the user must keep to this, the block does not enforce it.
//  Throughput: a sample that does not end an output row is taken every cycle.
//  A row-ending sample starts the serial divider, which works the 8 columns in
//  turn (bit-serial restoring divide, one unit shared by all columns); the row
//  then goes to the output register, and no sample is taken meanwhile. After
//  the image's final line, each padding row is copied with a read then a write
//  per column (one row-store port), plus one hand-off.
//  The output register holds a row while rsp_tready is low; samples keep
//  flowing up to the next row-ending word, whose row then waits for the register.
//  Reset (synchronous) clears sums, counters and the output valid; factors
//  return to 1. The row store needs no clearing.
module box_downsampler_8x8_block
   import bds_pkg::*;
#(
   parameter int SAMPLE_BITS = SampleBitsDflt
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [SAMPLE_BITS-1:0] sample, zero filled to whole bytes
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   // [0] line_is_final
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // out_0 .. out_7 (SAMPLE_BITS each), out_row (3), zero filled to bytes
   output logic [((8*SAMPLE_BITS+3+7)/8)*8-1:0] rsp_tdata,
   output logic                   rsp_tlast,   // block_last
   input  logic                   csr_we,
   input  logic [0:0]             csr_addr,
   input  logic [FactorW-1:0]     csr_wdata
);

   localparam int SumW = SAMPLE_BITS + 4;   // 16 summed samples

   bds_cmd_type            cmd;
   bds_status_type         st;
   logic [SAMPLE_BITS-1:0] rsp_col [BlockEdge];
   logic [2:0]             rsp_row;

   bds_ctrl #(.SUM_W(SumW)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   bds_datapath #(.SAMPLE_BITS(SAMPLE_BITS), .SUM_W(SumW)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .sample        (req_tdata[SAMPLE_BITS-1:0]),
      .line_is_final (req_tuser),
      .rsp_tready    (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .rsp_col       (rsp_col),
      .rsp_row       (rsp_row),
      .rsp_last      (rsp_tlast),
      .cmd           (cmd),
      .st            (st)
   );

   // pack the row, column 0 in the low bits
   always_comb begin
      rsp_tdata = '0;
      for (int c = 0; c < BlockEdge; c++) rsp_tdata[c*SAMPLE_BITS +: SAMPLE_BITS] = rsp_col[c];
      rsp_tdata[BlockEdge*SAMPLE_BITS +: 3] = rsp_row;
   end

endmodule
